// ===== sv/risc_instruction_execute_unit_defines.svh =====
// Assertion macros shared by the checker of the integer execute unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef RISC_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
`define RISC_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RIE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RIE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rie_pkg.sv =====
// Package of the integer execute unit: opcodes, field layout and shared types.
// Used by the top level, rie_exec and rie_checker; depends on nothing.
`default_nettype none

package rie_pkg;

    localparam int DEF_NUM_REGS   = 16;
    localparam int DEF_DMEM_WORDS = 4096;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int PC_W    = 16;
    localparam int OPC_W   = 5;
    localparam int RIDX_W  = 4;
    localparam int LIT_W   = 16;

    localparam logic [PC_W-1:0] RESET_CODE_BASE = 16'd4000;
    localparam logic [PC_W-1:0] PC_STEP         = 16'd4;

    // Request layout on s_tdata.
    localparam int OPC_LSB  = 0;
    localparam int DEST_LSB = OPC_LSB + OPC_W;
    localparam int SRCA_LSB = DEST_LSB + RIDX_W;
    localparam int SRCB_LSB = SRCA_LSB + RIDX_W;
    localparam int SRCC_LSB = SRCB_LSB + RIDX_W;
    localparam int LIT_LSB  = SRCC_LSB + RIDX_W;
    localparam int IN_BITS  = LIT_LSB + LIT_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;

    // Result layout on m_tdata; the written value sits at WVAL_LSB.
    localparam int NPC_LSB   = 0;
    localparam int RW_BIT    = NPC_LSB + PC_W;
    localparam int WREG_LSB  = RW_BIT + 1;
    localparam int WVAL_LSB  = WREG_LSB + RIDX_W;
    localparam int OUT_FIXED = WVAL_LSB + 4;

    localparam int OUT_DEPTH = 4;

    typedef enum logic [OPC_W-1:0] {
        OP_MOVC  = 5'd0,
        OP_ADD   = 5'd1,
        OP_ADDL  = 5'd2,
        OP_SUB   = 5'd3,
        OP_SUBL  = 5'd4,
        OP_MUL   = 5'd5,
        OP_AND   = 5'd6,
        OP_OR    = 5'd7,
        OP_XOR   = 5'd8,
        OP_LOAD  = 5'd9,
        OP_LDR   = 5'd10,
        OP_STORE = 5'd11,
        OP_STR   = 5'd12,
        OP_BZ    = 5'd13,
        OP_BNZ   = 5'd14,
        OP_JUMP  = 5'd15,
        OP_HALT  = 5'd16,
        OP_NOP   = 5'd17
    } op_t;

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            wr_reg;
        logic            is_load;
        logic            mem_wr;
        logic            fault;
        logic            set_zero;
        logic            halt_set;
    } exec_ctl_t;

endpackage

`default_nettype wire

// ===== sv/risc_instruction_execute_unit.sv =====
// Top level of the in-order integer execute unit.
// Depends on rie_pkg, rie_ram, rie_exec and rie_out_fifo.
//
// Usage:
// Each request on s_tdata is one decoded instruction; each produces exactly one
// result on m_tdata, in order. Operands are read from three copies of the
// register file; the data memory is a single synchronous RAM.
// A request is read in the cycle after it is taken, and most results enter the
// result queue at the end of that cycle; a LOAD or LDR that reads memory enters
// its result in the cycle after that, when the data memory read returns.
// Other instructions are taken one per cycle while the result queue has room.
// A LOAD or LDR, unless the unit is halted, blocks the next request while it
// sits in the read stage and the data memory read completes.
// Writes to cfg_wdata load the program counter and must be made while idle.
// After reset the data memory is cleared one word per cycle, so s_tready stays
// low until all DMEM_WORDS words (4096 by default) are cleared.
// When m_tready is low, results collect in a four-entry queue; s_tready drops
// once the queue and the pipeline together hold four results.
`default_nettype none

module risc_instruction_execute_unit #(
    parameter int NUM_REGS   = rie_pkg::DEF_NUM_REGS,
    parameter int DMEM_WORDS = rie_pkg::DEF_DMEM_WORDS,
    parameter int DATA_WIDTH = rie_pkg::DEF_DATA_WIDTH,
    localparam int IN_W  = rie_pkg::IN_W,
    localparam int OUT_W = ((rie_pkg::OUT_FIXED + DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [rie_pkg::PC_W-1:0]   cfg_wdata,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // opcode, dest_reg, src_a, src_b, src_c, literal
    input  wire logic [IN_W-1:0]            s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // next_pc, reg_written, written_reg, written_value, mem_written,
    // mem_fault, zero_now, halted_now
    output logic      [OUT_W-1:0]           m_tdata
);

    localparam int RAW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int IDX_W  = (RAW > rie_pkg::RIDX_W) ? RAW : rie_pkg::RIDX_W;
    localparam int DAW    = $clog2(DMEM_WORDS);
    localparam int MW_BIT = rie_pkg::WVAL_LSB + DATA_WIDTH;
    localparam int MF_BIT = MW_BIT + 1;
    localparam int Z_BIT  = MW_BIT + 2;
    localparam int H_BIT  = MW_BIT + 3;
    localparam int QCW    = $clog2(rie_pkg::OUT_DEPTH + 1);
    localparam int OCC_W  = $clog2(rie_pkg::OUT_DEPTH + 3);

    logic                         accept;
    logic [IDX_W-1:0]             in_dest_ext;
    logic [IDX_W-1:0]             in_a_ext;
    logic [IDX_W-1:0]             in_b_ext;
    logic [IDX_W-1:0]             in_c_ext;
    logic [RAW-1:0]               in_a_addr;
    logic [RAW-1:0]               in_b_addr;
    logic [RAW-1:0]               in_c_addr;

    logic                         clr_busy_reg;
    logic [DAW-1:0]               clr_cnt_reg;

    logic [rie_pkg::PC_W-1:0]     pc_reg;
    logic                         zero_reg;
    logic                         halt_reg;
    logic [NUM_REGS-1:0]          rf_valid_reg;

    logic                         r_valid_reg;
    rie_pkg::op_t                 r_op_reg;
    logic [IDX_W-1:0]             r_dest_reg;
    logic [rie_pkg::LIT_W-1:0]    r_lit_reg;
    logic [DATA_WIDTH-1:0]        r_fwd_reg;
    logic                         r_hit_a_reg;
    logic                         r_hit_b_reg;
    logic                         r_hit_c_reg;
    logic                         r_ok_a_reg;
    logic                         r_ok_b_reg;
    logic                         r_ok_c_reg;

    logic                         m_valid_reg;
    logic [IDX_W-1:0]             m_dest_reg;

    logic [DATA_WIDTH-1:0]        rf_a_rdata;
    logic [DATA_WIDTH-1:0]        rf_b_rdata;
    logic [DATA_WIDTH-1:0]        rf_c_rdata;
    logic [DATA_WIDTH-1:0]        opa;
    logic [DATA_WIDTH-1:0]        opb;
    logic [DATA_WIDTH-1:0]        opc;

    rie_pkg::exec_ctl_t           ex_ctl;
    logic [DATA_WIDTH-1:0]        ex_value;
    logic [DAW-1:0]               ex_addr;

    logic                         r_dest_ok;
    logic                         m_dest_ok;
    logic                         r_commit;
    logic                         r_zero_new;
    logic                         rf_we;
    logic [IDX_W-1:0]             rf_widx;
    logic [RAW-1:0]               rf_waddr;
    logic [DATA_WIDTH-1:0]        rf_wdata;

    logic                         dm_we;
    logic [DAW-1:0]               dm_waddr;
    logic [DATA_WIDTH-1:0]        dm_wdata;
    logic [DATA_WIDTH-1:0]        dm_rdata;

    logic                         q_push;
    logic [OUT_W-1:0]             q_data;
    logic [QCW-1:0]               q_count;
    logic [OCC_W-1:0]             occupancy;
    logic                         r_load_wait;

    assign in_dest_ext = IDX_W'(s_tdata[rie_pkg::DEST_LSB +: rie_pkg::RIDX_W]);
    assign in_a_ext    = IDX_W'(s_tdata[rie_pkg::SRCA_LSB +: rie_pkg::RIDX_W]);
    assign in_b_ext    = IDX_W'(s_tdata[rie_pkg::SRCB_LSB +: rie_pkg::RIDX_W]);
    assign in_c_ext    = IDX_W'(s_tdata[rie_pkg::SRCC_LSB +: rie_pkg::RIDX_W]);
    assign in_a_addr   = in_a_ext[RAW-1:0];
    assign in_b_addr   = in_b_ext[RAW-1:0];
    assign in_c_addr   = in_c_ext[RAW-1:0];

    // A load in the read stage holds off the next request until its data returns.
    assign r_load_wait = r_valid_reg && !halt_reg &&
                         (r_op_reg == rie_pkg::OP_LOAD || r_op_reg == rie_pkg::OP_LDR);
    assign occupancy   = OCC_W'(q_count) + OCC_W'(r_valid_reg) + OCC_W'(m_valid_reg);
    assign s_tready    = !clr_busy_reg && !r_load_wait &&
                         (occupancy < OCC_W'(rie_pkg::OUT_DEPTH));
    assign accept      = s_tvalid && s_tready;

    rie_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NUM_REGS)
    ) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (in_a_addr),
        .rdata (rf_a_rdata)
    );

    rie_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NUM_REGS)
    ) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (in_b_addr),
        .rdata (rf_b_rdata)
    );

    rie_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NUM_REGS)
    ) u_rf_c (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (in_c_addr),
        .rdata (rf_c_rdata)
    );

    // A write landing on the same edge as the read is forwarded; entries never
    // written since reset read as zero.
    assign opa = r_hit_a_reg ? r_fwd_reg : (r_ok_a_reg ? rf_a_rdata : '0);
    assign opb = r_hit_b_reg ? r_fwd_reg : (r_ok_b_reg ? rf_b_rdata : '0);
    assign opc = r_hit_c_reg ? r_fwd_reg : (r_ok_c_reg ? rf_c_rdata : '0);

    rie_exec #(
        .DATA_WIDTH (DATA_WIDTH),
        .DMEM_WORDS (DMEM_WORDS)
    ) u_exec (
        .opcode    (r_op_reg),
        .literal   (r_lit_reg),
        .opa       (opa),
        .opb       (opb),
        .opc       (opc),
        .pc        (pc_reg),
        .zero_flag (zero_reg),
        .halted    (halt_reg),
        .ctl       (ex_ctl),
        .value     (ex_value),
        .addr      (ex_addr)
    );

    assign r_dest_ok  = (r_dest_reg < NUM_REGS);
    assign m_dest_ok  = (m_dest_reg < NUM_REGS);
    assign r_commit   = r_valid_reg && !ex_ctl.is_load;
    assign r_zero_new = ex_ctl.set_zero ? (ex_value == '0) : zero_reg;

    assign rf_we    = (r_valid_reg && ex_ctl.wr_reg && r_dest_ok) ||
                      (m_valid_reg && m_dest_ok);
    assign rf_widx  = m_valid_reg ? m_dest_reg : r_dest_reg;
    assign rf_waddr = rf_widx[RAW-1:0];
    assign rf_wdata = m_valid_reg ? dm_rdata : ex_value;

    assign dm_we    = clr_busy_reg || (r_valid_reg && ex_ctl.mem_wr);
    assign dm_waddr = clr_busy_reg ? clr_cnt_reg : ex_addr;
    assign dm_wdata = clr_busy_reg ? '0 : opa;

    rie_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DMEM_WORDS)
    ) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .raddr (ex_addr),
        .rdata (dm_rdata)
    );

    always_comb
    begin
        q_data = '0;
        q_push = r_commit || m_valid_reg;
        if (m_valid_reg)
        begin
            q_data[rie_pkg::NPC_LSB +: rie_pkg::PC_W] = pc_reg;
            q_data[rie_pkg::RW_BIT] = m_dest_ok;
            if (m_dest_ok)
            begin
                q_data[rie_pkg::WREG_LSB +: rie_pkg::RIDX_W] =
                    rie_pkg::RIDX_W'(m_dest_reg);
                q_data[rie_pkg::WVAL_LSB +: DATA_WIDTH] = dm_rdata;
            end
            q_data[Z_BIT] = zero_reg;
            q_data[H_BIT] = halt_reg;
        end
        else
        begin
            q_data[rie_pkg::NPC_LSB +: rie_pkg::PC_W] = ex_ctl.next_pc;
            q_data[rie_pkg::RW_BIT] = ex_ctl.wr_reg && r_dest_ok;
            if (ex_ctl.wr_reg && r_dest_ok)
            begin
                q_data[rie_pkg::WREG_LSB +: rie_pkg::RIDX_W] =
                    rie_pkg::RIDX_W'(r_dest_reg);
                q_data[rie_pkg::WVAL_LSB +: DATA_WIDTH] = ex_value;
            end
            q_data[MW_BIT] = ex_ctl.mem_wr;
            q_data[MF_BIT] = ex_ctl.fault;
            q_data[Z_BIT]  = r_zero_new;
            q_data[H_BIT]  = halt_reg || ex_ctl.halt_set;
        end
    end

    rie_out_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (rie_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .count     (q_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            pc_reg       <= rie_pkg::RESET_CODE_BASE;
            zero_reg     <= 1'b0;
            halt_reg     <= 1'b0;
            rf_valid_reg <= '0;
            r_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == DAW'(DMEM_WORDS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cfg_we)
            begin
                pc_reg <= cfg_wdata;
            end
            else if (r_valid_reg)
            begin
                pc_reg <= ex_ctl.next_pc;
            end
            if (r_valid_reg)
            begin
                zero_reg <= r_zero_new;
                halt_reg <= halt_reg || ex_ctl.halt_set;
            end
            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            r_valid_reg <= accept;
            m_valid_reg <= r_valid_reg && ex_ctl.is_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r_op_reg    <= rie_pkg::op_t'(s_tdata[rie_pkg::OPC_LSB +: rie_pkg::OPC_W]);
            r_dest_reg  <= in_dest_ext;
            r_lit_reg   <= s_tdata[rie_pkg::LIT_LSB +: rie_pkg::LIT_W];
            r_fwd_reg   <= rf_wdata;
            r_hit_a_reg <= rf_we && (rf_widx == in_a_ext);
            r_hit_b_reg <= rf_we && (rf_widx == in_b_ext);
            r_hit_c_reg <= rf_we && (rf_widx == in_c_ext);
            r_ok_a_reg  <= (in_a_ext < NUM_REGS) && rf_valid_reg[in_a_addr];
            r_ok_b_reg  <= (in_b_ext < NUM_REGS) && rf_valid_reg[in_b_addr];
            r_ok_c_reg  <= (in_c_ext < NUM_REGS) && rf_valid_reg[in_c_addr];
        end
        if (r_valid_reg)
        begin
            m_dest_reg <= r_dest_reg;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rie_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the register file copies and the data memory; no dependencies.
`default_nettype none

module rie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/rie_exec.sv =====
// Execute logic of the integer unit: ALU, data address check, next program counter.
// Purely combinational; depends on rie_pkg.
`default_nettype none

module rie_exec #(
    parameter int DATA_WIDTH = rie_pkg::DEF_DATA_WIDTH,
    parameter int DMEM_WORDS = rie_pkg::DEF_DMEM_WORDS,
    localparam int DAW = $clog2(DMEM_WORDS)
) (
    input  wire rie_pkg::op_t                  opcode,
    input  wire logic [rie_pkg::LIT_W-1:0]     literal,
    input  wire logic [DATA_WIDTH-1:0]         opa,
    input  wire logic [DATA_WIDTH-1:0]         opb,
    input  wire logic [DATA_WIDTH-1:0]         opc,
    input  wire logic [rie_pkg::PC_W-1:0]      pc,
    input  wire logic                          zero_flag,
    input  wire logic                          halted,
    output rie_pkg::exec_ctl_t                 ctl,
    output logic      [DATA_WIDTH-1:0]         value,
    output logic      [DAW-1:0]                addr
);

    localparam int AEXT_W = (DATA_WIDTH > DAW) ? DATA_WIDTH : DAW;

    logic signed [rie_pkg::LIT_W-1:0] lit_s;
    logic        [DATA_WIDTH-1:0]     lit_x;
    logic        [DATA_WIDTH-1:0]     addr_x;
    logic        [DATA_WIDTH-1:0]     addr_y;
    logic        [DATA_WIDTH-1:0]     addr_sum;
    logic        [AEXT_W-1:0]         addr_ext;
    logic                             addr_ok;
    logic        [rie_pkg::PC_W-1:0]  a_pc;
    logic        [rie_pkg::PC_W-1:0]  pc_inc;
    logic        [rie_pkg::PC_W-1:0]  pc_branch;
    logic        [rie_pkg::PC_W-1:0]  pc_jump;

    assign lit_s     = literal;
    assign lit_x     = DATA_WIDTH'(lit_s);
    assign a_pc      = rie_pkg::PC_W'(opa);
    assign pc_inc    = pc + rie_pkg::PC_STEP;
    assign pc_branch = pc + literal;
    assign pc_jump   = a_pc + literal;

    always_comb
    begin
        case (opcode)
            rie_pkg::OP_LOAD, rie_pkg::OP_LDR: addr_x = opa;
            rie_pkg::OP_STORE:                 addr_x = opb;
            default:                           addr_x = opc;
        endcase
        case (opcode)
            rie_pkg::OP_LOAD, rie_pkg::OP_STORE: addr_y = lit_x;
            default:                             addr_y = opb;
        endcase
    end

    assign addr_sum = addr_x + addr_y;
    assign addr_ext = AEXT_W'(addr_sum);
    assign addr     = addr_ext[DAW-1:0];
    assign addr_ok  = !addr_sum[DATA_WIDTH-1] && (addr_sum < DMEM_WORDS);

    always_comb
    begin
        ctl         = '0;
        ctl.next_pc = pc_inc;
        value       = '0;
        if (halted)
        begin
            ctl.next_pc = pc;
        end
        else
        begin
            case (opcode)
                rie_pkg::OP_MOVC:
                begin
                    value      = lit_x;
                    ctl.wr_reg = 1'b1;
                end
                rie_pkg::OP_ADD:
                begin
                    value        = opa + opb;
                    ctl.wr_reg   = 1'b1;
                    ctl.set_zero = 1'b1;
                end
                rie_pkg::OP_ADDL:
                begin
                    value        = opa + lit_x;
                    ctl.wr_reg   = 1'b1;
                    ctl.set_zero = 1'b1;
                end
                rie_pkg::OP_SUB:
                begin
                    value        = opa - opb;
                    ctl.wr_reg   = 1'b1;
                    ctl.set_zero = 1'b1;
                end
                rie_pkg::OP_SUBL:
                begin
                    value        = opa - lit_x;
                    ctl.wr_reg   = 1'b1;
                    ctl.set_zero = 1'b1;
                end
                rie_pkg::OP_MUL:
                begin
                    value        = opa * opb;
                    ctl.wr_reg   = 1'b1;
                    ctl.set_zero = 1'b1;
                end
                rie_pkg::OP_AND:
                begin
                    value      = opa & opb;
                    ctl.wr_reg = 1'b1;
                end
                rie_pkg::OP_OR:
                begin
                    value      = opa | opb;
                    ctl.wr_reg = 1'b1;
                end
                rie_pkg::OP_XOR:
                begin
                    value      = opa ^ opb;
                    ctl.wr_reg = 1'b1;
                end
                rie_pkg::OP_LOAD, rie_pkg::OP_LDR:
                begin
                    ctl.is_load = addr_ok;
                    ctl.fault   = !addr_ok;
                end
                rie_pkg::OP_STORE, rie_pkg::OP_STR:
                begin
                    ctl.mem_wr = addr_ok;
                    ctl.fault  = !addr_ok;
                end
                rie_pkg::OP_BZ:
                begin
                    if (zero_flag)
                    begin
                        ctl.next_pc = pc_branch;
                    end
                end
                rie_pkg::OP_BNZ:
                begin
                    if (!zero_flag)
                    begin
                        ctl.next_pc = pc_branch;
                    end
                end
                rie_pkg::OP_JUMP:
                begin
                    ctl.next_pc = pc_jump;
                end
                rie_pkg::OP_HALT:
                begin
                    ctl.next_pc  = pc;
                    ctl.halt_set = 1'b1;
                end
                default:
                begin
                    ctl.next_pc = pc_inc;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/rie_out_fifo.sv =====
// Result queue of the integer execute unit, held in flip-flops.
// Decouples the execute pipeline from the output stream; depends on nothing.
`default_nettype none

module rie_out_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data,
    output logic      [CW-1:0]    count
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rie_checker.sv =====
// Port-level checker of the integer execute unit and its bind to the top level.
// Depends on rie_pkg and risc_instruction_execute_unit_defines.svh.
`default_nettype none
`include "risc_instruction_execute_unit_defines.svh"

module rie_checker #(
    parameter int OUT_W      = 64,
    parameter int DATA_WIDTH = rie_pkg::DEF_DATA_WIDTH
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    localparam int MW_BIT = rie_pkg::WVAL_LSB + DATA_WIDTH;
    localparam int MF_BIT = MW_BIT + 1;
    localparam int H_BIT  = MW_BIT + 3;

    logic seen_halt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready && m_tdata[H_BIT])
        begin
            seen_halt_reg <= 1'b1;
        end
    end

    `RIE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `RIE_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    `RIE_ASSERT_NOW(a_halt_sticky, m_tvalid && seen_halt_reg, m_tdata[H_BIT], "halt flag cleared without reset")
    `RIE_ASSERT_NOW(a_halt_quiet, m_tvalid && m_tdata[H_BIT], !m_tdata[rie_pkg::RW_BIT] && !m_tdata[MW_BIT] && !m_tdata[MF_BIT], "write or fault reported while halted")

endmodule

bind risc_instruction_execute_unit rie_checker #(
    .OUT_W      (OUT_W),
    .DATA_WIDTH (DATA_WIDTH)
) u_rie_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
